### sv/sitoa_pkg.sv
// ----------------------------------------------------------------------------
// Signed integer to decimal text: shared definitions
// Widths, character codes, the queue entry and the conversion state type.
// ----------------------------------------------------------------------------
package sitoa_pkg;

   localparam int VALUE_W     = 32;
   localparam int CHAR_W      = 8;
   localparam int NUM_DIGITS  = 10;
   localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);
   localparam int STEP_W      = $clog2(VALUE_W);
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

   localparam logic [STEP_W-1:0]      STEP_LAST = STEP_W'(VALUE_W - 1);
   localparam logic [DIGIT_IDX_W-1:0] DIGIT_LSD = '0;

   typedef struct packed {
      logic               negative;
      logic [VALUE_W-1:0] magnitude;
   } sitoa_entry_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_CONV,
      BK_SIGN,
      BK_DIGITS
   } sitoa_state_type;

endpackage

### sv/sitoa_front.sv
// ----------------------------------------------------------------------------
// Signed integer to decimal text: front end
// Accepts one integer per item, splits it into sign and unsigned magnitude
// and holds the result until the queue takes it.
// ----------------------------------------------------------------------------
module sitoa_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [sitoa_pkg::VALUE_W-1:0] req_value,
   output logic                             push_valid,
   input  logic                             push_ready,
   output sitoa_pkg::sitoa_entry_type       push_entry
);
   import sitoa_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   sitoa_entry_type entry_ff;
   sitoa_entry_type entry_in;
   logic            req_fire;

   assign req_ready = !valid_ff || push_ready;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      entry_in.negative  = req_value[VALUE_W-1];
      entry_in.magnitude = req_value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(req_value))
                                                : VALUE_W'(req_value);
      valid_in = req_fire || (valid_ff && !push_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         entry_ff <= entry_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_entry = entry_ff;

endmodule

### sv/sitoa_fifo.sv
// ----------------------------------------------------------------------------
// Signed integer to decimal text: item queue
// A short first-in first-out queue between the front end and the converter.
// DEPTH must be at least 2.
// ----------------------------------------------------------------------------
module sitoa_fifo #(
   parameter int DEPTH = sitoa_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   output logic                       push_ready,
   input  sitoa_pkg::sitoa_entry_type push_entry,
   output logic                       pop_valid,
   input  logic                       pop_ready,
   output sitoa_pkg::sitoa_entry_type pop_entry
);
   import sitoa_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   sitoa_entry_type store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_entry  = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### sv/sitoa_back.sv
// ----------------------------------------------------------------------------
// Signed integer to decimal text: converter and character sender
// Turns the magnitude into decimal digits by shift-and-add-three, one bit
// per cycle, then sends the sign and the significant digits one per item.
// ----------------------------------------------------------------------------
module sitoa_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              pop_valid,
   output logic                              pop_ready,
   input  sitoa_pkg::sitoa_entry_type        pop_entry,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [sitoa_pkg::CHAR_W-1:0]      rsp_char_code,
   output logic                              rsp_last_char
);
   import sitoa_pkg::*;

   sitoa_state_type          state_ff;
   sitoa_state_type          state_in;
   logic [VALUE_W-1:0]       bin_ff;
   logic [VALUE_W-1:0]       bin_in;
   logic [3:0]               bcd_ff [NUM_DIGITS];
   logic [3:0]               bcd_in [NUM_DIGITS];
   logic [3:0]               bcd_step [NUM_DIGITS];
   logic [3:0]               bcd_adj [NUM_DIGITS];
   logic                     neg_ff;
   logic                     neg_in;
   logic [STEP_W-1:0]        step_ff;
   logic [STEP_W-1:0]        step_in;
   logic [DIGIT_IDX_W-1:0]   dig_idx_ff;
   logic [DIGIT_IDX_W-1:0]   dig_idx_in;
   logic [DIGIT_IDX_W-1:0]   top_idx;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [CHAR_W-1:0]        rsp_char_ff;
   logic [CHAR_W-1:0]        rsp_char_in;
   logic                     rsp_last_ff;
   logic                     rsp_last_in;
   logic                     slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // One shift-and-add-three step over all digits.
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         bcd_adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
      bcd_step[0] = {bcd_adj[0][2:0], bin_ff[VALUE_W-1]};
      for (int i = 1; i < NUM_DIGITS; i++) begin
         bcd_step[i] = {bcd_adj[i][2:0], bcd_adj[i-1][3]};
      end
   end

   // Position of the most significant nonzero digit; zero when all are zero.
   always_comb begin
      top_idx = DIGIT_LSD;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i] != 4'd0) begin
            top_idx = DIGIT_IDX_W'(i);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (pop_valid) begin
               state_in = BK_CONV;
            end
         end
         BK_CONV: begin
            if (step_ff == STEP_LAST) begin
               state_in = BK_SIGN;
            end
         end
         BK_SIGN: begin
            if (slot_free || !neg_ff) begin
               state_in = BK_DIGITS;
            end
         end
         BK_DIGITS: begin
            if (slot_free && (dig_idx_ff == DIGIT_LSD)) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      pop_ready    = 1'b0;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      neg_in       = neg_ff;
      step_in      = step_ff;
      dig_idx_in   = dig_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         BK_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               bin_in  = pop_entry.magnitude;
               neg_in  = pop_entry.negative;
               step_in = '0;
               for (int i = 0; i < NUM_DIGITS; i++) begin
                  bcd_in[i] = 4'd0;
               end
            end
         end
         BK_CONV: begin
            bin_in  = {bin_ff[VALUE_W-2:0], 1'b0};
            bcd_in  = bcd_step;
            step_in = step_ff + 1'b1;
         end
         BK_SIGN: begin
            dig_idx_in = top_idx;
            if (neg_ff && slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = ASCII_MINUS;
               rsp_last_in  = 1'b0;
            end
         end
         BK_DIGITS: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = ASCII_ZERO + {4'd0, bcd_ff[dig_idx_ff]};
               rsp_last_in  = (dig_idx_ff == DIGIT_LSD);
               dig_idx_in   = dig_idx_ff - 1'b1;
            end
         end
         default: begin
            pop_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      neg_ff      <= neg_in;
      step_ff     <= step_in;
      dig_idx_ff  <= dig_idx_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;

`ifndef SYNTH
   a_conv_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_CONV && step_ff == STEP_LAST) |=> (state_ff == BK_SIGN))
      else $error("Conversion did not end after the last bit.");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_char_ff == ASCII_MINUS) |-> !rsp_last_ff)
      else $error("A minus sign was flagged as the last character.");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DIGITS && slot_free && dig_idx_ff == DIGIT_LSD)
      |=> (rsp_valid_ff && rsp_last_ff && state_ff == BK_IDLE))
      else $error("The final digit did not close the item.");

   a_pop_starts_conv: assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_ready) |=> (state_ff == BK_CONV && step_ff == '0))
      else $error("A queue entry was taken without starting a conversion.");
`endif

endmodule

### sv/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// Signed integer to decimal text
// Renders a 32-bit two's-complement integer as ASCII decimal characters.
// ----------------------------------------------------------------------------
// Each accepted item is a signed 32-bit integer, and it produces one to
// eleven result items, one ASCII character each, most significant first:
// a minus sign for negative values, then the digits without leading zeros,
// with the last character flagged. Zero gives the single character '0'.
// An item is registered in the front end and then waits in a short
// queue; the converter takes it, runs a shift-and-add-three loop with
// one step per bit of the magnitude, then sends the minus sign, if any,
// and the digits, each as soon as the output slot is free. The converter
// takes no new item until the last character of the current one is
// issued; the front end and queue accept new items meanwhile until the
// queue is full.
module signed_int_to_decimal_ascii #(
   parameter int QUEUE_DEPTH = sitoa_pkg::QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [sitoa_pkg::VALUE_W-1:0] req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [sitoa_pkg::CHAR_W-1:0]         rsp_char_code,
   output logic                                 rsp_last_char
);
   import sitoa_pkg::*;

   logic            push_valid;
   logic            push_ready;
   sitoa_entry_type push_entry;
   logic            pop_valid;
   logic            pop_ready;
   sitoa_entry_type pop_entry;

   sitoa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_value  (req_value),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   sitoa_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   sitoa_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_entry     (pop_entry),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_last_char (rsp_last_char)
   );

endmodule
